// File: design/crz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coefficient round and zero runs: shared package
// Field widths, symbol constants, result kinds and the result record type.
// ----------------------------------------------------------------------------
package crz_pkg;

	localparam int CoefW     = 16;
	localparam int SymbolW   = 11;
	localparam int PosW      = 14;
	localparam int NzCountW  = 15;
	localparam int RunCountW = 14;
	localparam int SideLogW  = 3;

	localparam int MaxSideDefault = 128;

	localparam logic [SideLogW-1:0] SideLogReset = 3'd3;
	localparam logic [SideLogW-1:0] SideLogMin   = 3'd2;

	// Symbol offset and clamp limit, kept as 13-bit signed values.
	localparam logic signed [12:0] SymbolOffset = 13'sd900;
	localparam logic signed [12:0] SymbolMax    = 13'sd2047;

	// Result kinds carried in tuser.
	localparam logic KIND_COEF    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Output tdata width: the packed fields rounded up to whole bytes.
	localparam int OutFieldsW = SymbolW + 2 + 2 * PosW + NzCountW + RunCountW;
	localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

	typedef struct packed {
		logic                 kind;
		logic [SymbolW-1:0]   symbol;
		logic                 saturated;
		logic                 run_valid;
		logic [PosW-1:0]      run_first;
		logic [PosW-1:0]      run_final;
		logic [NzCountW-1:0]  nonzero_total;
		logic [RunCountW-1:0] run_total;
		logic                 last;
	} result_t;

endpackage

// File: design/coefficient_round_and_zero_runs_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coefficient round and zero runs unit
// Rounds scan-ordered 12.4 coefficients, emits a clamped symbol per nonzero
// value with the zero run it closes, and a count summary at the end of block.
// ----------------------------------------------------------------------------
// A coefficient is held in the input stage register, then written to the
// result queue, whose head drives the master side. Throughput: one
// coefficient per cycle while the queue has room; a nonzero final coefficient
// of a block makes two results. The input stage advances while at least two
// of the four result queue entries are free. Reset (arst_n low, asynchronous)
// clears the block state, empties the queue and sets block_side_log2 to 3.
module coefficient_round_and_zero_runs_unit #(
	parameter int MAX_SIDE = crz_pkg::MaxSideDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration: block_side_log2.
	input  logic                          cfg_wr_en,
	input  logic [crz_pkg::SideLogW-1:0]  cfg_wr_data,
	// Slave side. tdata: coefficient [15:0].
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [crz_pkg::CoefW-1:0]     s_tdata,
	// Master side.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// tdata: symbol [10:0], saturated [11], run_valid [12], run_first [26:13],
	// run_final [40:27], nonzero_total [55:41], run_total [69:56], zero pad.
	output logic [crz_pkg::OutDataW-1:0]  m_tdata,
	// tuser: kind.
	output logic                          m_tuser,
	output logic                          m_tlast
);

	// Largest usable side log2, from the floor of log2(MAX_SIDE), within 2..7.
	localparam int SideLogCapRaw = $clog2(MAX_SIDE + 1) - 1;
	localparam int SideLogCapInt = (SideLogCapRaw < 2) ? 2 :
		((SideLogCapRaw > 7) ? 7 : SideLogCapRaw);
	localparam logic [crz_pkg::SideLogW-1:0] SideLogCap =
		crz_pkg::SideLogW'(SideLogCapInt);

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);
	localparam logic [QCntW-1:0] QAdvLimit = QCntW'(QDepth - 2);

	// Configuration register.
	logic [crz_pkg::SideLogW-1:0] side_log_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_log_q <= crz_pkg::SideLogReset;
		end else if (cfg_wr_en) begin
			side_log_q <= cfg_wr_data;
		end
	end

	// Input stage register.
	logic                      valid_s1;
	logic [crz_pkg::CoefW-1:0] coef_s1;
	logic                      advance;
	logic                      s_xfer;
	logic [QCntW-1:0]          q_cnt_q;

	assign advance  = valid_s1 && (q_cnt_q <= QAdvLimit);
	assign s_tready = !valid_s1 || advance;
	assign s_xfer   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			coef_s1 <= s_tdata;
		end
	end

	// Rounding: half away from zero on the magnitude, then restore the sign.
	logic                     coef_neg;
	logic [16:0]              coef_ext;
	logic [16:0]              mag;
	logic [16:0]              mag_p8;
	logic [11:0]              rmag;
	logic signed [12:0]       rounded;
	logic signed [12:0]       sym_sum;
	logic                     nonzero;
	logic                     sat_lo;
	logic                     sat_hi;
	logic [crz_pkg::SymbolW-1:0] symbol;

	always_comb begin
		coef_neg = coef_s1[15];
		coef_ext = {coef_s1[15], coef_s1};
		mag      = coef_neg ? (17'd0 - coef_ext) : coef_ext;
		mag_p8   = mag + 17'd8;
		rmag     = mag_p8[15:4];
		rounded  = coef_neg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
		nonzero  = (rmag != 12'd0);
		sym_sum  = rounded + crz_pkg::SymbolOffset;
		sat_lo   = sym_sum < 13'sd0;
		sat_hi   = sym_sum > crz_pkg::SymbolMax;
		if (sat_lo) begin
			symbol = '0;
		end else if (sat_hi) begin
			symbol = crz_pkg::SymbolMax[crz_pkg::SymbolW-1:0];
		end else begin
			symbol = sym_sum[crz_pkg::SymbolW-1:0];
		end
	end

	// Block end detection from the effective side.
	logic [crz_pkg::SideLogW-1:0] side_log_used;
	logic [crz_pkg::PosW-1:0]     last_pos;
	logic [crz_pkg::PosW-1:0]     pos_q;
	logic                         ends;

	always_comb begin
		if (side_log_q < crz_pkg::SideLogMin) begin
			side_log_used = crz_pkg::SideLogMin;
		end else if (side_log_q > SideLogCap) begin
			side_log_used = SideLogCap;
		end else begin
			side_log_used = side_log_q;
		end
		last_pos = crz_pkg::PosW'((15'd1 << {side_log_used, 1'b0}) - 15'd1);
		ends     = pos_q >= last_pos;
	end

	// Run tracking and block counters.
	logic                          in_run_q;
	logic [crz_pkg::PosW-1:0]      run_first_q;
	logic [crz_pkg::PosW-1:0]      run_final_q;
	logic [crz_pkg::NzCountW-1:0]  nz_cnt_q;
	logic [crz_pkg::RunCountW-1:0] run_cnt_q;
	logic [crz_pkg::NzCountW-1:0]  nz_cnt_next;
	logic [crz_pkg::RunCountW-1:0] run_cnt_next;

	assign nz_cnt_next  = nonzero ? (nz_cnt_q + 1'b1) : nz_cnt_q;
	assign run_cnt_next = (nonzero && in_run_q) ? (run_cnt_q + 1'b1) : run_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			in_run_q    <= 1'b0;
			run_first_q <= '0;
			run_final_q <= '0;
			nz_cnt_q    <= '0;
			run_cnt_q   <= '0;
		end else if (advance) begin
			if (ends) begin
				pos_q       <= '0;
				in_run_q    <= 1'b0;
				run_first_q <= '0;
				run_final_q <= '0;
				nz_cnt_q    <= '0;
				run_cnt_q   <= '0;
			end else begin
				pos_q     <= pos_q + 1'b1;
				nz_cnt_q  <= nz_cnt_next;
				run_cnt_q <= run_cnt_next;
				if (nonzero) begin
					in_run_q <= 1'b0;
				end else begin
					if (!in_run_q) begin
						run_first_q <= pos_q;
					end
					run_final_q <= pos_q;
					in_run_q    <= 1'b1;
				end
			end
		end
	end

	// Result records for this coefficient.
	crz_pkg::result_t coef_res;
	crz_pkg::result_t sum_res;

	always_comb begin
		coef_res.kind          = crz_pkg::KIND_COEF;
		coef_res.symbol        = symbol;
		coef_res.saturated     = sat_lo || sat_hi;
		coef_res.run_valid     = in_run_q;
		coef_res.run_first     = in_run_q ? run_first_q : '0;
		coef_res.run_final     = in_run_q ? run_final_q : '0;
		coef_res.nonzero_total = '0;
		coef_res.run_total     = '0;
		coef_res.last          = !ends;

		sum_res.kind          = crz_pkg::KIND_SUMMARY;
		sum_res.symbol        = '0;
		sum_res.saturated     = 1'b0;
		sum_res.run_valid     = 1'b0;
		sum_res.run_first     = '0;
		sum_res.run_final     = '0;
		sum_res.nonzero_total = nz_cnt_next;
		sum_res.run_total     = run_cnt_next;
		sum_res.last          = 1'b1;
	end

	// Result queue: up to two writes and one read per cycle.
	crz_pkg::result_t  q_mem [QDepth];
	logic [QPtrW-1:0]  q_wr_q;
	logic [QPtrW-1:0]  q_rd_q;
	logic              push_a;
	logic              push_b;
	logic [1:0]        push_n;
	logic              pop;
	crz_pkg::result_t  entry_a;

	assign push_a  = advance && (nonzero || ends);
	assign push_b  = advance && nonzero && ends;
	assign push_n  = {1'b0, push_a} + {1'b0, push_b};
	assign entry_a = nonzero ? coef_res : sum_res;
	assign m_tvalid = (q_cnt_q != '0);
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= '0;
			q_rd_q  <= '0;
			q_cnt_q <= '0;
		end else begin
			q_wr_q  <= q_wr_q + QPtrW'(push_n);
			q_rd_q  <= q_rd_q + QPtrW'(pop);
			q_cnt_q <= q_cnt_q + QCntW'(push_n) - QCntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_a) begin
			q_mem[q_wr_q] <= entry_a;
		end
		if (push_b) begin
			q_mem[q_wr_q + 1'b1] <= sum_res;
		end
	end

	// Output packing from the queue head.
	crz_pkg::result_t head;

	assign head    = q_mem[q_rd_q];
	assign m_tuser = head.kind;
	assign m_tlast = head.last;
	assign m_tdata = crz_pkg::OutDataW'({head.run_total, head.nonzero_total,
		head.run_final, head.run_first, head.run_valid, head.saturated,
		head.symbol});

endmodule

// File: design/crz_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coefficient round and zero runs: port checker
// Watches the master side of the top level and is bound to every instance.
// ----------------------------------------------------------------------------
module crz_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [crz_pkg::OutDataW-1:0] m_tdata,
	input  logic                         m_tuser,
	input  logic                         m_tlast
);

	// A summary always closes the results of its coefficient.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == crz_pkg::KIND_SUMMARY)) |-> m_tlast)
	else $error("summary result without tlast");

	// A summary carries only the two counts.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == crz_pkg::KIND_SUMMARY)) |-> (m_tdata[40:0] == '0))
	else $error("summary result with coefficient fields set");

	// A closed run never ends before it starts.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == crz_pkg::KIND_COEF) && m_tdata[12])
			|-> (m_tdata[26:13] <= m_tdata[40:27]))
	else $error("closed run bounds out of order");

	// A stalled result holds until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
	else $error("stalled result changed");

endmodule

bind coefficient_round_and_zero_runs_unit crz_checker u_crz_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
